FILE: rtl/core/assert_macros.svh
// assertion helpers for the picture frame extractor
// in simulation, each macro expands to a concurrent assertion on the rising clock edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked only while reset is released
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/core/id3pfx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package id3pfx_pkg;

  localparam int unsigned TAG_W = 28;
  localparam int unsigned LEN_W = 32;
  localparam logic [TAG_W-1:0] MAX_TAG_RESET = TAG_W'(50 * 1024 * 1024);
  localparam logic [7:0] SYNC_MASK = 8'h7F;

  // parser phases
  typedef enum logic [3:0] {
    PH_HDR   = 4'd0,
    PH_FHDR  = 4'd1,
    PH_SKIP  = 4'd2,
    PH_ENC   = 4'd3,
    PH_MIME  = 4'd4,
    PH_TYPE  = 4'd5,
    PH_DESC  = 4'd6,
    PH_IMAGE = 4'd7,
    PH_DONE  = 4'd8
  } phase_t;

  // result codes
  typedef enum logic [2:0] {
    OC_IMAGE    = 3'd0,
    OC_NO_HDR   = 3'd1,
    OC_BAD_SIZE = 3'd2,
    OC_NO_PIC   = 3'd3,
    OC_TRUNC    = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    outcome_t   outcome;
  } result_t;

  // handshake between the input stage and the parser/output stage
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

  // "ID3" signature byte by position
  function automatic logic [7:0] id3_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h49;
      2'd1:    c = 8'h44;
      2'd2:    c = 8'h33;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "APIC" frame id byte by position
  function automatic logic [7:0] apic_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h41;
      2'd1:    c = 8'h50;
      2'd2:    c = 8'h49;
      2'd3:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/id3v2_picture_frame_extractor_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// ID3v2 attached-picture extractor: streams the image bytes of the first
// APIC frame of an MP3 file that arrives one byte per transfer.
// input channel: in_data_byte with in_file_start / in_file_end markers,
//   transferred when in_valid is high and in_stall is low
// result channel: out_out_byte, out_last, out_outcome, transferred when
//   out_valid is high and out_stall is low; image bytes carry outcome 0,
//   a status result carries byte 0 and last 1
// cfg_wr_en writes cfg_max_tag_bytes, the largest accepted tag size
// a byte's result passes the input register, then the result register;
//   bytes with no result only update the parser state
// throughput: one byte per cycle while the receiver does not stall, set by
//   the combinational parser step between the input and result registers
// reset: both registers empty, parser waits for a file header, the tag
//   size limit returns to 50 MiB
// a stalled receiver holds the result register; while it is held, in_stall
//   is high whenever the input register holds a byte, so no byte is lost
module id3v2_picture_frame_extractor_unit
  import id3pfx_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [TAG_W-1:0] cfg_max_tag_bytes,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_file_start,
  input  wire logic             in_file_end,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_out_byte,
  output logic                  out_last,
  output logic [2:0]            out_outcome
);

  in_item_t   in_item;
  in_item_t   item;
  stage_ctl_t ctl;
  logic       out_ready;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign in_item = '{data_byte: in_data_byte, file_start: in_file_start,
                     file_end: in_file_end};

  // input register
  id3pfx_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_ready (out_ready),
    .ctl       (ctl),
    .item      (item)
  );

  // parser state and per-byte step
  id3pfx_parser u_parser (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_max_tag_bytes (cfg_max_tag_bytes),
    .step              (ctl.advance),
    .item              (item),
    .res_valid         (res_valid),
    .res               (res)
  );

  // result register
  id3pfx_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ctl.advance && res_valid),
    .res       (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_out_byte = out_res.out_byte;
  assign out_last     = out_res.last;
  assign out_outcome  = out_res.outcome;

endmodule

`default_nettype wire

FILE: rtl/core/id3pfx_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module id3pfx_in_reg
  import id3pfx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  input  wire logic       out_ready,
  output stage_ctl_t      ctl,
  output in_item_t        item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     take;

  // item leaves the stage when the output side can hold its result
  assign take        = valid_r && out_ready;
  assign in_stall    = valid_r && !out_ready;
  assign ctl.valid   = valid_r;
  assign ctl.advance = take;
  assign item        = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && !in_stall) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/id3pfx_parser.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module id3pfx_parser
  import id3pfx_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [TAG_W-1:0] cfg_max_tag_bytes,
  input  wire logic             step,
  input  wire in_item_t         item,
  output logic                  res_valid,
  output result_t               res
);

  logic [TAG_W-1:0] max_tag_r;
  phase_t           phase_r, phase_nxt, phase_c;
  logic [3:0]       field_r, field_nxt, field_c;
  logic             v24_r, v24_nxt, v24_c;
  logic             apic_r, apic_nxt;
  // remaining tag bytes (holds the tag size while the header is read)
  logic [TAG_W-1:0] tag_r, tag_nxt, tag_c;
  // frame size, then remaining frame bytes
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] len_prev;
  logic [7:0]       b;
  logic             file_closed;

  assign b = item.data_byte;

  // phase after a final result
  assign file_closed = (phase_r == PH_HDR) || (phase_r == PH_DONE);

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tag_r <= MAX_TAG_RESET;
    end else if (cfg_wr_en) begin
      max_tag_r <= cfg_max_tag_bytes;
    end
  end

  // one byte of parsing
  always_comb begin
    phase_c = item.file_start ? PH_HDR : phase_r;
    field_c = item.file_start ? 4'd0 : field_r;
    v24_c   = item.file_start ? 1'b0 : v24_r;
    tag_c   = item.file_start ? '0 : tag_r;

    phase_nxt = phase_c;
    field_nxt = field_c;
    v24_nxt   = v24_c;
    apic_nxt  = apic_r;
    tag_nxt   = tag_c;
    len_nxt   = len_r;
    len_prev  = (field_c == 4'd4) ? '0 : len_r;
    res_valid = 1'b0;
    res       = '{out_byte: 8'd0, last: 1'b0, outcome: OC_IMAGE};

    case (phase_c)
      PH_HDR: begin
        if (field_c < 4'd3 && b != id3_char(field_c[1:0])) begin
          res_valid = 1'b1;
          res       = '{out_byte: 8'd0, last: 1'b1, outcome: OC_NO_HDR};
          phase_nxt = PH_DONE;
        end else begin
          if (field_c == 4'd3) begin
            v24_nxt = (b == 8'd4);
          end
          if (field_c >= 4'd6) begin
            tag_nxt = {tag_c[TAG_W-8:0], b[6:0] & SYNC_MASK[6:0]};
          end
          if (field_c >= 4'd9) begin
            if (tag_nxt == '0 || tag_nxt > max_tag_r) begin
              res_valid = 1'b1;
              res       = '{out_byte: 8'd0, last: 1'b1, outcome: OC_BAD_SIZE};
              phase_nxt = PH_DONE;
            end else if (tag_nxt < TAG_W'(10)) begin
              res_valid = 1'b1;
              res       = '{out_byte: 8'd0, last: 1'b1, outcome: OC_NO_PIC};
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_FHDR;
              field_nxt = 4'd0;
            end
          end else begin
            field_nxt = field_c + 4'd1;
          end
        end
      end
      PH_FHDR: begin
        tag_nxt = tag_c - TAG_W'(1);
        if (field_c == 4'd0 && b == 8'd0) begin
          // padding reached
          res_valid = 1'b1;
          res       = '{out_byte: 8'd0, last: 1'b1, outcome: OC_NO_PIC};
          phase_nxt = PH_DONE;
        end else begin
          if (field_c == 4'd0) begin
            apic_nxt = (b == apic_char(2'd0));
          end else if (field_c < 4'd4) begin
            apic_nxt = apic_r && (b == apic_char(field_c[1:0]));
          end else if (field_c < 4'd8) begin
            len_nxt = v24_c ? {len_prev[LEN_W-8:0], b[6:0] & SYNC_MASK[6:0]}
                            : {len_prev[LEN_W-9:0], b};
          end
          if (field_c >= 4'd9) begin
            // frame must fit in what is left of the tag
            if (len_r == '0 || len_r >= {{(LEN_W-TAG_W){1'b0}}, tag_c}) begin
              res_valid = 1'b1;
              res       = '{out_byte: 8'd0, last: 1'b1, outcome: OC_NO_PIC};
              phase_nxt = PH_DONE;
            end else if (apic_r && len_r > LEN_W'(4)) begin
              phase_nxt = PH_ENC;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end else begin
            field_nxt = field_c + 4'd1;
          end
        end
      end
      PH_SKIP, PH_ENC, PH_MIME, PH_TYPE, PH_DESC, PH_IMAGE: begin
        tag_nxt = tag_c - TAG_W'(1);
        len_nxt = len_r - LEN_W'(1);
        case (phase_c)
          PH_SKIP: begin
            if (len_r == LEN_W'(1)) begin
              if (tag_c < TAG_W'(11)) begin
                res_valid = 1'b1;
                res       = '{out_byte: 8'd0, last: 1'b1, outcome: OC_NO_PIC};
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_FHDR;
                field_nxt = 4'd0;
              end
            end
          end
          PH_ENC: begin
            phase_nxt = PH_MIME;
          end
          PH_MIME: begin
            if (len_r == LEN_W'(1)) begin
              res_valid = 1'b1;
              res       = '{out_byte: 8'd0, last: 1'b1, outcome: OC_NO_PIC};
              phase_nxt = PH_DONE;
            end else if (b == 8'd0) begin
              phase_nxt = PH_TYPE;
            end
          end
          PH_TYPE: begin
            if (len_r == LEN_W'(1)) begin
              res_valid = 1'b1;
              res       = '{out_byte: 8'd0, last: 1'b1, outcome: OC_NO_PIC};
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_DESC;
            end
          end
          PH_DESC: begin
            if (b == 8'd0 && len_r != LEN_W'(1)) begin
              phase_nxt = PH_IMAGE;
            end else if (b == 8'd0 && tag_c >= TAG_W'(11)) begin
              // empty image, go on to the next frame
              phase_nxt = PH_FHDR;
              field_nxt = 4'd0;
            end else if (len_r == LEN_W'(1)) begin
              res_valid = 1'b1;
              res       = '{out_byte: 8'd0, last: 1'b1, outcome: OC_NO_PIC};
              phase_nxt = PH_DONE;
            end
          end
          default: begin
            // image byte
            res_valid = 1'b1;
            res       = '{out_byte: b, last: 1'b0, outcome: OC_IMAGE};
            if (len_r == LEN_W'(1)) begin
              res.last  = 1'b1;
              phase_nxt = PH_DONE;
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    // end of file: report an open file, then restart
    if (item.file_end) begin
      if (phase_nxt != PH_DONE) begin
        if (res_valid) begin
          res.outcome = OC_TRUNC;
        end else begin
          res_valid = 1'b1;
          res.out_byte = 8'd0;
          if (phase_nxt == PH_HDR) begin
            res.outcome = OC_NO_HDR;
          end else if (phase_nxt == PH_IMAGE) begin
            res.outcome = OC_TRUNC;
          end else begin
            res.outcome = OC_NO_PIC;
          end
        end
        res.last = 1'b1;
      end
      phase_nxt = PH_HDR;
      field_nxt = 4'd0;
      v24_nxt   = 1'b0;
      tag_nxt   = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      field_r <= 4'd0;
      v24_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      field_r <= field_nxt;
      v24_r   <= v24_nxt;
    end
  end

  // counters and frame id match
  always_ff @(posedge clk) begin
    if (step) begin
      apic_r <= apic_nxt;
      tag_r  <= tag_nxt;
      len_r  <= len_nxt;
    end
  end

  `ASSERT_ALWAYS(a_reset_to_hdr, clk, !rst_n |=> phase_r == PH_HDR)
  `ASSERT_RST(a_status_is_last, clk, rst_n, res_valid && res.outcome != OC_IMAGE |-> res.last)
  `ASSERT_RST(a_last_closes_file, clk, rst_n, step && res_valid && res.last |=> file_closed)
  `ASSERT_RST(a_image_len_live, clk, rst_n, phase_r == PH_IMAGE |-> len_r != '0)

endmodule

`default_nettype wire

FILE: rtl/core/id3pfx_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module id3pfx_out_reg
  import id3pfx_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res,
  output logic         ready,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // room when empty or when the held result transfers this cycle
  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire
